### sv/bbmv_pkg.sv
// ----------------------------------------------------------------------------
// bbmv_pkg
// shared types, constants and fixed-point helpers for the billboard
// model-view matrix core
// ----------------------------------------------------------------------------
package bbmv_pkg;

   localparam int DATA_W        = 32;
   localparam int ACC_W         = 67;
   localparam int SPRITE_W      = 15;
   localparam int SLOT_W        = 5;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MQ_DEPTH_DEF  = 2;
   localparam int RSP_DEPTH_DEF = 4;

   localparam logic [SLOT_W-1:0] SLOT_SPRITE = 5'd16;
   localparam logic [1:0]        ROT_LAST    = 2'd2;
   localparam logic [DATA_W-1:0] SAT_MAX     = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_MIN     = 32'h8000_0000;

   // view matrix element (col, row) sits at index {col, row}
   typedef logic [15:0][DATA_W-1:0] view_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   pos_x;
      logic signed [DATA_W-1:0]   pos_y;
      logic signed [DATA_W-1:0]   pos_z;
      logic signed [DATA_W-1:0]   scale_x;
      logic signed [DATA_W-1:0]   scale_y;
      logic signed [DATA_W-1:0]   scale_z;
      logic        [SPRITE_W-1:0] sprite_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic        [SLOT_W-1:0] slot;
      logic                     last;
   } rsp_type;

   // scaled rotation [col][row], position [axis], sprite index
   typedef struct packed {
      logic [2:0][2:0][DATA_W-1:0] rot;
      logic [2:0][DATA_W-1:0]      pos;
      logic [SPRITE_W-1:0]         sprite;
   } model_type;

   // round half up to frac fraction bits, saturate to 32 bits
   function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                                   input int frac);
      logic signed [ACC_W-1:0]  half;
      logic signed [ACC_W-1:0]  sh;
      logic [ACC_W-DATA_W:0]    top;
      half = '0;
      half[frac-1] = 1'b1;
      sh = (acc + half) >>> frac;
      top = sh[ACC_W-1:DATA_W-1];
      if (top == '0 || top == '1) begin
         return sh[DATA_W-1:0];
      end else if (sh[ACC_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   function automatic view_type ident_view(input int frac);
      view_type v;
      v = '0;
      for (int i = 0; i < 4; i++) begin
         v[i*5] = DATA_W'(64'd1 << frac);
      end
      return v;
   endfunction

endpackage

### sv/billboard_model_view_matrix_core.sv
// ----------------------------------------------------------------------------
// billboard_model_view_matrix_core
// spherical billboard model-view matrix generator, signed fixed point
// ----------------------------------------------------------------------------
// Each particle transfer yields 17 result transfers: the model-view entries
// column-major (slot 4*col+row), then the sprite index as fixed point with
// last set. The back end issues one result per cycle through four parallel
// multiply lanes while a model is queued and the output queue has room. The
// front end forms the nine scaled rotation products on one multiplier, ends
// the last product in a flush state, hands off in a push state, and runs
// ahead through a two-entry model queue. The view matrix registers reset to
// identity; the user must write them only while idle, as the core itself
// does not enforce this.
module billboard_model_view_matrix_core #(
   parameter int FRAC_BITS = bbmv_pkg::FRAC_BITS_DEF,
   parameter int MQ_DEPTH  = bbmv_pkg::MQ_DEPTH_DEF,
   parameter int RSP_DEPTH = bbmv_pkg::RSP_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  bbmv_pkg::req_type                   req_data,
   output logic                                empty,
   input  logic                                pop,
   output bbmv_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [bbmv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bbmv_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bbmv_pkg::*;

   localparam view_type VIEW_RESET = ident_view(FRAC_BITS);

   view_type  view_ff;
   logic      mq_push, mq_full, mq_empty, mq_pop;
   model_type mq_in, mq_out;

   // register i holds view elements 2i (low word) and 2i+1 (high word)
   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff <= VIEW_RESET;
      end else if (csr_write_en) begin
         view_ff[{csr_index, 1'b0}] <= csr_data[DATA_W-1:0];
         view_ff[{csr_index, 1'b1}] <= csr_data[2*DATA_W-1:DATA_W];
      end
   end

   bbmv_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .view     (view_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .mq_push  (mq_push),
      .mq_full  (mq_full),
      .mq_data  (mq_in)
   );

   bbmv_fifo #(
      .WIDTH ($bits(model_type)),
      .DEPTH (MQ_DEPTH)
   ) u_model_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (mq_push),
      .data_in  (mq_in),
      .full     (mq_full),
      .pop      (mq_pop),
      .data_out (mq_out),
      .empty    (mq_empty),
      .count    ()
   );

   bbmv_back #(
      .FRAC_BITS (FRAC_BITS),
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .view     (view_ff),
      .mq_empty (mq_empty),
      .mq_pop   (mq_pop),
      .mq_data  (mq_out),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

### sv/bbmv_fifo.sv
// ----------------------------------------------------------------------------
// bbmv_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module bbmv_fifo #(
   parameter int WIDTH = bbmv_pkg::DATA_W,
   parameter int DEPTH = bbmv_pkg::MQ_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             data_in,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             data_out,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import bbmv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign count    = cnt_ff;
   assign data_out = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

### sv/bbmv_front.sv
// ----------------------------------------------------------------------------
// bbmv_front
// accepts particles and builds the scaled rotation part of the model matrix,
// one product per cycle, then hands the model to the back end queue
// ----------------------------------------------------------------------------
module bbmv_front #(
   parameter int FRAC_BITS = bbmv_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bbmv_pkg::view_type    view,
   input  logic                  push,
   output logic                  full,
   input  bbmv_pkg::req_type     req_data,
   output logic                  mq_push,
   input  logic                  mq_full,
   output bbmv_pkg::model_type   mq_data
);
   import bbmv_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_FLUSH, ST_PUSH} state_type;

   state_type                    state_ff;
   req_type                      item_ff;
   logic [1:0]                   c_ff, r_ff, pc_ff, pr_ff;
   logic                         p_v_ff;
   logic signed [2*DATA_W-1:0]   prod_ff;
   logic [2:0][2:0][DATA_W-1:0]  rot_ff;
   logic signed [DATA_W-1:0]     view_op, scale_op;
   logic                         accept, push_done, step_last;

   assign push_done = (state_ff == ST_PUSH) && !mq_full;
   assign full      = !((state_ff == ST_IDLE) || push_done);
   assign accept    = push && !full;
   assign mq_push   = (state_ff == ST_PUSH);
   assign step_last = (c_ff == ROT_LAST) && (r_ff == ROT_LAST);

   always_comb begin
      mq_data.rot    = rot_ff;
      mq_data.pos[0] = item_ff.pos_x;
      mq_data.pos[1] = item_ff.pos_y;
      mq_data.pos[2] = item_ff.pos_z;
      mq_data.sprite = item_ff.sprite_index;
   end

   // model[c][r] = view(col r, row c) * scale[c]
   always_comb begin
      view_op = view[{r_ff, c_ff}];
      case (c_ff)
         2'd0:    scale_op = item_ff.scale_x;
         2'd1:    scale_op = item_ff.scale_y;
         default: scale_op = item_ff.scale_z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_v_ff   <= 1'b0;
      end else begin
         p_v_ff <= (state_ff == ST_CALC);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (step_last) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (!mq_full) begin
                  state_ff <= accept ? ST_CALC : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (accept) begin
         item_ff <= req_data;
         c_ff    <= '0;
         r_ff    <= '0;
      end else if (state_ff == ST_CALC) begin
         if (r_ff == ROT_LAST) begin
            r_ff <= '0;
            c_ff <= c_ff + 1'b1;
         end else begin
            r_ff <= r_ff + 1'b1;
         end
      end
      if (state_ff == ST_CALC) begin
         prod_ff <= view_op * scale_op;
         pc_ff   <= c_ff;
         pr_ff   <= r_ff;
      end
      if (p_v_ff) begin
         rot_ff[pc_ff][pr_ff] <= round_sat(ACC_W'(prod_ff), FRAC_BITS);
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CALC)
      else $error("accepted particle did not start the rotation pass");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> c_ff <= ROT_LAST && r_ff <= ROT_LAST)
      else $error("rotation step counter out of range");

endmodule

### sv/bbmv_back.sv
// ----------------------------------------------------------------------------
// bbmv_back
// sequences the 17 results of each queued model: four multiply lanes form
// one model-view entry per cycle when credit allows, then the sprite index;
// results go to an output queue under credit control
// ----------------------------------------------------------------------------
module bbmv_back #(
   parameter int FRAC_BITS = bbmv_pkg::FRAC_BITS_DEF,
   parameter int RSP_DEPTH = bbmv_pkg::RSP_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bbmv_pkg::view_type    view,
   input  logic                  mq_empty,
   output logic                  mq_pop,
   input  bbmv_pkg::model_type   mq_data,
   output logic                  empty,
   input  logic                  pop,
   output bbmv_pkg::rsp_type     rsp_data
);
   import bbmv_pkg::*;

   localparam int CNT_W = $clog2(RSP_DEPTH+1);

   logic [SLOT_W-1:0]           slot_ff;
   logic                        issue, credit_ok;
   logic [3:0][3:0][DATA_W-1:0] mat;
   logic signed [DATA_W-1:0]    a_op [4];
   logic signed [DATA_W-1:0]    b_op [4];
   logic [2*DATA_W-1:0]         spr_wide;
   logic [DATA_W-1:0]           spr_val;

   logic                        p1_v_ff, p2_v_ff;
   logic [SLOT_W-1:0]           p1_slot_ff, p2_slot_ff;
   logic [DATA_W-1:0]           p1_spr_ff, p2_spr_ff;
   logic signed [2*DATA_W-1:0]  p1_prod_ff [4];
   logic signed [2*DATA_W:0]    p2_sum_ff [2];
   logic signed [2*DATA_W+1:0]  total;

   logic                        res_full;
   logic [CNT_W-1:0]            res_count;
   rsp_type                     res_data;

   assign credit_ok = ((CNT_W+1)'(res_count) + (CNT_W+1)'(p1_v_ff) + (CNT_W+1)'(p2_v_ff))
                      < (CNT_W+1)'(RSP_DEPTH);
   assign issue     = !mq_empty && credit_ok;
   assign mq_pop    = issue && (slot_ff == SLOT_SPRITE);

   // full model matrix [col][row]
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 3; k++) begin
            mat[c][k] = mq_data.rot[c][k];
         end
         mat[c][3] = '0;
      end
      for (int k = 0; k < 3; k++) begin
         mat[3][k] = mq_data.pos[k];
      end
      mat[3][3] = DATA_W'(64'd1 << FRAC_BITS);
   end

   // entry (c, r) = sum over k of view(col k, row r) * model[c][k]
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_op[k] = view[{2'(k), slot_ff[1:0]}];
         b_op[k] = mat[slot_ff[3:2]][k];
      end
   end

   assign spr_wide = (2*DATA_W)'(mq_data.sprite) << FRAC_BITS;
   assign spr_val  = (|spr_wide[2*DATA_W-1:DATA_W-1]) ? SAT_MAX : spr_wide[DATA_W-1:0];

   assign total = (2*DATA_W+2)'(p2_sum_ff[0]) + (2*DATA_W+2)'(p2_sum_ff[1]);

   always_comb begin
      res_data.slot  = p2_slot_ff;
      res_data.last  = (p2_slot_ff == SLOT_SPRITE);
      res_data.value = (p2_slot_ff == SLOT_SPRITE) ? p2_spr_ff
                                                   : round_sat(ACC_W'(total), FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue;
         p2_v_ff <= p1_v_ff;
         if (issue) begin
            slot_ff <= (slot_ff == SLOT_SPRITE) ? '0 : slot_ff + 1'b1;
         end
      end
      if (issue) begin
         p1_slot_ff <= slot_ff;
         p1_spr_ff  <= spr_val;
         for (int k = 0; k < 4; k++) begin
            p1_prod_ff[k] <= a_op[k] * b_op[k];
         end
      end
      p2_slot_ff   <= p1_slot_ff;
      p2_spr_ff    <= p1_spr_ff;
      p2_sum_ff[0] <= (2*DATA_W+1)'(p1_prod_ff[0]) + (2*DATA_W+1)'(p1_prod_ff[1]);
      p2_sum_ff[1] <= (2*DATA_W+1)'(p1_prod_ff[2]) + (2*DATA_W+1)'(p1_prod_ff[3]);
   end

   bbmv_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (p2_v_ff),
      .data_in  (res_data),
      .full     (res_full),
      .pop      (pop),
      .data_out (rsp_data),
      .empty    (empty),
      .count    (res_count)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      p2_v_ff |-> !res_full)
      else $error("result written into full output queue");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W+1)'(res_count) + (CNT_W+1)'(p1_v_ff) + (CNT_W+1)'(p2_v_ff)
         <= (CNT_W+1)'(RSP_DEPTH))
      else $error("results in flight exceed output queue space");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_SPRITE)
      else $error("result slot counter out of range");

endmodule

### dv/billboard_model_view_matrix_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_model_view_matrix_core_tb
// self-checking testbench for the billboard model-view matrix core
// ----------------------------------------------------------------------------
// Particles go in through the push/full queue port and the 17 result words of
// each one come back through empty/pop. A directed table runs first: identity
// view rows carry their expected words directly, the saturation and rounding
// rows under extreme view matrices go through the in-bench matrix predictor.
// Several random phases follow with fresh view matrices, random idling on both
// sides, a long receiver hold-off that backs the core up, and a stretch with
// no idling at all. A watchdog ends the run if transfers stop.
module billboard_model_view_matrix_core_tb;
   import bbmv_pkg::*;

   localparam int FRAC           = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int NUM_DIRECTED   = 19;
   localparam logic signed [DATA_W-1:0] FX_ONE = 32'sd1 <<< FRAC;

   typedef enum logic [2:0] {
      VIEW_IDENT, VIEW_MAX, VIEW_MIN, VIEW_ULP, VIEW_NEG_ULP, VIEW_RANDOM
   } view_mode_t;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_C0_R01, CSR_VIEW_C0_R23, CSR_VIEW_C1_R01, CSR_VIEW_C1_R23,
      CSR_VIEW_C2_R01, CSR_VIEW_C2_R23, CSR_VIEW_C3_R01, CSR_VIEW_C3_R23
   } csr_reg_t;

   typedef struct {
      view_mode_t mode;
      bit         ident;
      req_type    item;
   } directed_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   req_type                req_data = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [CSR_DATA_W-1:0]  view_csr [8];
   rsp_type                mv_expected [$];
   rsp_type                oldest_expected;
   directed_row_t          directed_rows [NUM_DIRECTED];
   int                     mismatches = 0;
   int                     quiet_cycles = 0;
   bit                     tx_steady = 1'b0;
   bit                     rx_steady = 1'b0;
   bit                     rsp_hold_request = 1'b0;

   billboard_model_view_matrix_core uut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic signed [DATA_W-1:0] view_entry(input int col, input int row);
      logic [CSR_DATA_W-1:0] word;
      word = view_csr[col * 2 + row / 2];
      return (row % 2) ? word[63:32] : word[31:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] round_to_q(input logic signed [ACC_W:0] acc);
      logic signed [ACC_W:0] q;
      q = (acc + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (q > 68'sd2147483647) begin
         return SAT_MAX;
      end else if (q < -68'sd2147483648) begin
         return SAT_MIN;
      end
      return q[DATA_W-1:0];
   endfunction

   // model = transposed view rotation scaled per column, position in column 3
   function automatic void predict_model_view(input req_type p);
      logic signed [DATA_W-1:0] model [4][4];
      logic signed [DATA_W-1:0] scl [3];
      logic signed [ACC_W:0]    acc;
      scl[0] = p.scale_x;
      scl[1] = p.scale_y;
      scl[2] = p.scale_z;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            acc = view_entry(r, c) * scl[c];
            model[c][r] = round_to_q(acc);
         end
         model[c][3] = '0;
      end
      model[3][0] = p.pos_x;
      model[3][1] = p.pos_y;
      model[3][2] = p.pos_z;
      model[3][3] = FX_ONE;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               acc = acc + view_entry(k, r) * model[c][k];
            end
            mv_expected.push_back(rsp_type'{round_to_q(acc), SLOT_W'(4 * c + r), 1'b0});
         end
      end
   endfunction

   function automatic logic [DATA_W-1:0] random_fixed();
      logic [DATA_W-1:0] w;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: w = SAT_MAX;
               1: w = SAT_MIN;
               2: w = '0;
               3: w = FX_ONE;
               default: w = -FX_ONE;
            endcase
         end
         1, 2: begin
            w = $urandom();
         end
         default: begin
            w = $urandom();
            w = {{12{w[19]}}, w[19:0]};
         end
      endcase
      return w;
   endfunction

   function automatic req_type random_particle();
      req_type p;
      p.pos_x        = random_fixed();
      p.pos_y        = random_fixed();
      p.pos_z        = random_fixed();
      p.scale_x      = random_fixed();
      p.scale_y      = random_fixed();
      p.scale_z      = random_fixed();
      p.sprite_index = SPRITE_W'($urandom_range(32767));
      return p;
   endfunction

   function automatic logic [DATA_W-1:0] view_value(input view_mode_t mode, input int col,
                                                    input int row);
      case (mode)
         VIEW_IDENT:   return (col == row) ? FX_ONE : '0;
         VIEW_MAX:     return SAT_MAX;
         VIEW_MIN:     return SAT_MIN;
         VIEW_ULP:     return 32'h0000_0001;
         VIEW_NEG_ULP: return 32'hffff_ffff;
         default:      return random_fixed();
      endcase
   endfunction

   // drain, let the core settle, then rewrite all eight view registers
   task automatic load_view(input view_mode_t mode);
      csr_reg_t reg_id;
      int       col;
      int       row;
      push <= 1'b0;
      while (mv_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         reg_id = csr_reg_t'(i);
         col = i / 2;
         row = 2 * (i % 2);
         view_csr[reg_id] = {view_value(mode, col, row + 1), view_value(mode, col, row)};
         csr_write_en <= 1'b1;
         csr_index    <= reg_id;
         csr_data     <= view_csr[reg_id];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic send_particle(input req_type p, input bit ident);
      bit                       accepted;
      logic signed [DATA_W-1:0] scl [3];
      logic signed [DATA_W-1:0] v;
      if (!tx_steady) begin
         if ($urandom_range(19) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            while ($urandom_range(99) < 38) begin
               push <= 1'b0;
               @(posedge clock);
            end
         end
      end
      push     <= 1'b1;
      req_data <= p;
      do begin
         @(negedge clock);
         accepted = !full;
         @(posedge clock);
      end while (!accepted);
      if (ident) begin
         // identity view: model-view equals the model matrix
         scl[0] = p.scale_x;
         scl[1] = p.scale_y;
         scl[2] = p.scale_z;
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               if (c == 3) begin
                  v = (r == 0) ? p.pos_x : (r == 1) ? p.pos_y : (r == 2) ? p.pos_z : FX_ONE;
               end else begin
                  v = (r == c) ? scl[c] : '0;
               end
               mv_expected.push_back(rsp_type'{v, SLOT_W'(4 * c + r), 1'b0});
            end
         end
      end else begin
         predict_model_view(p);
      end
      mv_expected.push_back(rsp_type'{DATA_W'(p.sprite_index) << FRAC, SLOT_SPRITE, 1'b1});
   endtask

   // receiver
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pop <= rx_steady || ($urandom_range(99) >= 38);
         end
      end
   end

   // result check and watchdog
   always @(negedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (mv_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: value %h slot %0d last %b",
                           rsp_data.value, rsp_data.slot, rsp_data.last);
               end
            end else begin
               oldest_expected = mv_expected.pop_front();
               if (rsp_data.value !== oldest_expected.value ||
                   rsp_data.slot !== oldest_expected.slot ||
                   rsp_data.last !== oldest_expected.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected value %h slot %0d last %b, got value %h slot %0d last %b",
                              oldest_expected.value, oldest_expected.slot, oldest_expected.last,
                              rsp_data.value, rsp_data.slot, rsp_data.last);
                  end
               end
            end
         end
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL billboard_model_view_matrix_core");
            $finish;
         end
      end
   end

   initial begin
      view_mode_t cur_mode;
      for (int i = 0; i < 8; i++) begin
         view_csr[i] = {view_value(VIEW_IDENT, i / 2, 2 * (i % 2) + 1),
                        view_value(VIEW_IDENT, i / 2, 2 * (i % 2))};
      end
      directed_rows = '{
         // reset view is identity
         '{VIEW_IDENT, 1'b1, req_type'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 15'h0}},
         '{VIEW_IDENT, 1'b1, req_type'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 15'h1}},
         '{VIEW_IDENT, 1'b1, req_type'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 15'h7fff}},
         '{VIEW_IDENT, 1'b1, req_type'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h0}},
         '{VIEW_IDENT, 1'b1, req_type'{32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                                       32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 15'h5555}},
         '{VIEW_IDENT, 1'b1, req_type'{32'h1234_5678, 32'hedcb_a988, 32'h0000_8000,
                                       32'hffff_8000, 32'h0000_8000, 32'hfffe_0000, 15'h2aaa}},
         // saturation under extreme views
         '{VIEW_MAX, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 15'h7fff}},
         '{VIEW_MAX, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h0}},
         '{VIEW_MAX, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 15'h10}},
         '{VIEW_MAX, 1'b0, req_type'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h0, 32'h0, 32'h0, 15'h1}},
         '{VIEW_MIN, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 15'h3}},
         '{VIEW_MIN, 1'b0, req_type'{32'h7fff_ffff, 32'h0, 32'h8000_0000,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h7ffe}},
         '{VIEW_MIN, 1'b0, req_type'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 15'h100}},
         // rounding ties toward plus infinity
         '{VIEW_ULP, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 15'h2}},
         '{VIEW_ULP, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                     32'hffff_8000, 32'hffff_8000, 32'hffff_8000, 15'h4}},
         '{VIEW_ULP, 1'b0, req_type'{32'h0000_7fff, 32'h0000_8000, 32'hffff_8000,
                                     32'h0001_8000, 32'h0000_7fff, 32'hffff_7fff, 15'h8}},
         '{VIEW_NEG_ULP, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                         32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 15'h20}},
         '{VIEW_NEG_ULP, 1'b0, req_type'{32'h0, 32'h0, 32'h0,
                                         32'hffff_8000, 32'hffff_8000, 32'hffff_8000, 15'h40}},
         '{VIEW_NEG_ULP, 1'b0, req_type'{32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                                         32'h0002_8000, 32'hfffd_8000, 32'h0000_0000, 15'h80}}
      };
      wait (!reset);
      @(posedge clock);
      cur_mode = VIEW_IDENT;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != cur_mode) begin
            load_view(directed_rows[i].mode);
            cur_mode = directed_rows[i].mode;
         end
         send_particle(directed_rows[i].item, directed_rows[i].ident);
      end
      for (int ph = 0; ph < 5; ph++) begin
         tx_steady = (ph == 1) || (ph == 2);
         rx_steady = (ph == 2);
         load_view((ph == 2) ? VIEW_IDENT : VIEW_RANDOM);
         if (ph == 1) begin
            rsp_hold_request = 1'b1;
         end
         repeat (100) send_particle(random_particle(), 1'b0);
      end
      push <= 1'b0;
      while (mv_expected.size() != 0) @(posedge clock);
      rx_steady = 1'b1;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS billboard_model_view_matrix_core");
      end else begin
         $display("FAIL billboard_model_view_matrix_core");
      end
      $finish;
   end

endmodule

### filelist.f
sv/bbmv_pkg.sv
sv/bbmv_fifo.sv
sv/bbmv_front.sv
sv/bbmv_back.sv
sv/billboard_model_view_matrix_core.sv
dv/billboard_model_view_matrix_core_tb.sv
